### rtl/tsa_pkg.sv
`default_nettype none
// ============================================================================
// tsa_pkg
// Types and constants shared by the triangle strip assembler modules.
// ============================================================================
package tsa_pkg;

   localparam int unsigned VERTEX_WIDTH = 15;
   localparam int unsigned WORD_WIDTH   = 16;
   localparam int unsigned RESTART_POS  = 15;
   localparam logic [1:0]  FULL_WINDOW  = 2'd2;

   // One input word: a strip index and the end-of-list flag.
   typedef struct packed {
      logic [WORD_WIDTH-1:0] index_word;
      logic                  list_end;
   } req_type;

   // One emitted triangle.
   typedef struct packed {
      logic [VERTEX_WIDTH-1:0] first_vertex;
      logic [VERTEX_WIDTH-1:0] second_vertex;
      logic [VERTEX_WIDTH-1:0] third_vertex;
      logic                    run_last;
   } rsp_type;

   // Classified work handed from the front to the back. The first vertex is
   // the held word (with its restart decision), the second the closing word
   // of a list.
   typedef struct packed {
      logic                    held_valid;
      logic [VERTEX_WIDTH-1:0] held_vertex;
      logic                    held_restart;
      logic                    last_valid;
      logic [VERTEX_WIDTH-1:0] last_vertex;
      logic                    list_end;
   } cmd_type;

endpackage : tsa_pkg
`default_nettype wire

### rtl/triangle_strip_assembler.sv
`default_nettype none
// ============================================================================
// triangle_strip_assembler
// Turns a stream of strip index words with restart markers into triangles.
// ============================================================================
//  Channel  Direction  Handshake          Word
//  req_     in         req_push/req_full  index_word, list_end
//  rsp_     out        rsp_pop/rsp_empty  first/second/third_vertex, run_last
//
//  One word is accepted per cycle while the command queue has space.
//  An accepted word passes through the registered command queue and then
//  the registered triangle queue before its triangles show on the rsp_ ports.
//  The back end takes a command only when two triangle slots are free.
//  Reset clears the held word, the strip window and both queues.
//  Stalls on rsp_pop back up into the command queue and then req_full.
// ============================================================================
module triangle_strip_assembler #(
   parameter int unsigned CMD_DEPTH = 2,
   parameter int unsigned RSP_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire tsa_pkg::req_type req_word,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output tsa_pkg::rsp_type      rsp_word
);
   import tsa_pkg::*;

   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd_word;

   tsa_front #(
      .CMD_DEPTH (CMD_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_word  (cmd_word)
   );

   tsa_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_word  (cmd_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

endmodule : triangle_strip_assembler
`default_nettype wire

### rtl/tsa_front.sv
`default_nettype none
// ============================================================================
// tsa_front
// Holds one word back, decides strip restarts and queues vertex commands.
// ============================================================================
module tsa_front #(
   parameter int unsigned CMD_DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire tsa_pkg::req_type req_word,
   output logic                  cmd_empty,
   input  wire logic             cmd_pop,
   output tsa_pkg::cmd_type      cmd_word
);
   import tsa_pkg::*;

   localparam int unsigned PW = $clog2(CMD_DEPTH);
   localparam int unsigned CW = $clog2(CMD_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(CMD_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(CMD_DEPTH);

   logic [WORD_WIDTH-1:0] held_word_ff, held_word_in;
   logic                  held_valid_ff, held_valid_in;
   cmd_type               queue_ff [CMD_DEPTH];
   logic [PW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;

   logic    accept;
   logic    push;
   logic    pop;
   cmd_type new_cmd;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      return (ptr == LAST_PTR) ? '0 : ptr + PW'(1);
   endfunction

   assign req_full  = (count_ff == DEPTH_CNT);
   assign cmd_empty = (count_ff == '0);
   assign cmd_word  = queue_ff[rd_ptr_ff];

   assign accept = req_push & ~req_full;
   // The first word of a list that is not also its last produces no work yet.
   assign push   = accept & (held_valid_ff | req_word.list_end);
   assign pop    = cmd_pop & ~cmd_empty;

   always_comb begin
      new_cmd.held_valid   = held_valid_ff;
      new_cmd.held_vertex  = held_word_ff[VERTEX_WIDTH-1:0];
      new_cmd.held_restart = held_word_ff[RESTART_POS] & req_word.index_word[RESTART_POS];
      new_cmd.last_valid   = req_word.list_end;
      new_cmd.last_vertex  = req_word.index_word[VERTEX_WIDTH-1:0];
      new_cmd.list_end     = req_word.list_end;
   end

   always_comb begin
      held_word_in  = held_word_ff;
      held_valid_in = held_valid_ff;
      if (accept) begin
         if (req_word.list_end) begin
            held_word_in  = '0;
            held_valid_in = 1'b0;
         end else begin
            held_word_in  = req_word.index_word;
            held_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_word_ff  <= '0;
         held_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         held_word_ff  <= held_word_in;
         held_valid_ff <= held_valid_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("command queue count exceeds its depth");

   a_end_clears_held: assert property (@(posedge clock) disable iff (reset)
      accept && req_word.list_end |=> !held_valid_ff && held_word_ff == '0)
      else $error("held word survived the end of a list");

   a_word_held: assert property (@(posedge clock) disable iff (reset)
      accept && !req_word.list_end |=>
         held_valid_ff && held_word_ff == $past(req_word.index_word))
      else $error("accepted word was not held back");

endmodule : tsa_front
`default_nettype wire

### rtl/tsa_back.sv
`default_nettype none
// ============================================================================
// tsa_back
// Runs the strip window and winding, and queues the emitted triangles.
// ============================================================================
module tsa_back #(
   parameter int unsigned RSP_DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             cmd_empty,
   output logic                  cmd_pop,
   input  wire tsa_pkg::cmd_type cmd_word,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output tsa_pkg::rsp_type      rsp_word
);
   import tsa_pkg::*;

   localparam int unsigned PW = $clog2(RSP_DEPTH);
   localparam int unsigned CW = $clog2(RSP_DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(RSP_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(RSP_DEPTH);
   localparam logic [CW-1:0] ROOM_NEED = CW'(2);

   typedef struct packed {
      logic [VERTEX_WIDTH-1:0] older;
      logic [VERTEX_WIDTH-1:0] newer;
      logic [1:0]              fill;
      logic                    swapped;
   } strip_type;

   localparam strip_type STRIP_RESET = '0;

   strip_type     strip_ff, strip_in;
   rsp_type       queue_ff [RSP_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic      fire;
   logic      pop;
   strip_type s_held_start, s_after_held, s_after_last;
   logic      made_held, made_last;
   rsp_type   tri_held, tri_last;
   logic [1:0] n_made;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      return (ptr == LAST_PTR) ? '0 : ptr + PW'(1);
   endfunction

   function automatic rsp_type make_tri(input strip_type s,
                                        input logic [VERTEX_WIDTH-1:0] v);
      rsp_type t;
      if (s.swapped) begin
         t.first_vertex = v;
         t.third_vertex = s.older;
      end else begin
         t.first_vertex = s.older;
         t.third_vertex = v;
      end
      t.second_vertex = s.newer;
      t.run_last      = 1'b1;
      return t;
   endfunction

   function automatic strip_type advance(input strip_type s,
                                         input logic [VERTEX_WIDTH-1:0] v);
      strip_type n;
      n.older   = s.newer;
      n.newer   = v;
      n.fill    = (s.fill == FULL_WINDOW) ? FULL_WINDOW : s.fill + 2'd1;
      n.swapped = (s.fill == FULL_WINDOW) ? ~s.swapped : s.swapped;
      return n;
   endfunction

   assign rsp_empty = (count_ff == '0);
   assign rsp_word  = queue_ff[rd_ptr_ff];
   assign pop       = rsp_pop & ~rsp_empty;

   // A command may emit two triangles, so it waits for two free slots.
   assign fire    = ~cmd_empty & ((DEPTH_CNT - count_ff) >= ROOM_NEED);
   assign cmd_pop = fire;

   always_comb begin
      s_held_start = cmd_word.held_restart ? STRIP_RESET : strip_ff;
      made_held    = cmd_word.held_valid & (s_held_start.fill == FULL_WINDOW);
      tri_held     = make_tri(s_held_start, cmd_word.held_vertex);
      s_after_held = cmd_word.held_valid ? advance(s_held_start, cmd_word.held_vertex)
                                         : strip_ff;

      made_last    = cmd_word.last_valid & (s_after_held.fill == FULL_WINDOW);
      tri_last     = make_tri(s_after_held, cmd_word.last_vertex);
      s_after_last = cmd_word.last_valid ? advance(s_after_held, cmd_word.last_vertex)
                                         : s_after_held;

      // When both fire, only the second closes the run of this word.
      if (made_held && made_last) begin
         tri_held.run_last = 1'b0;
      end

      n_made = {1'b0, made_held} + {1'b0, made_last};
   end

   always_comb begin
      strip_in = strip_ff;
      if (fire) begin
         strip_in = cmd_word.list_end ? STRIP_RESET : s_after_last;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (fire) begin
         case (n_made)
            2'd1:    wr_ptr_in = next_ptr(wr_ptr_ff);
            2'd2:    wr_ptr_in = next_ptr(next_ptr(wr_ptr_ff));
            default: wr_ptr_in = wr_ptr_ff;
         endcase
      end
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + (fire ? CW'(n_made) : '0) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strip_ff  <= STRIP_RESET;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         strip_ff  <= strip_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         if (made_held) begin
            queue_ff[wr_ptr_ff] <= tri_held;
            if (made_last) begin
               queue_ff[next_ptr(wr_ptr_ff)] <= tri_last;
            end
         end else if (made_last) begin
            queue_ff[wr_ptr_ff] <= tri_last;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("triangle queue count exceeds its depth");

   a_end_resets_strip: assert property (@(posedge clock) disable iff (reset)
      fire && cmd_word.list_end |=> strip_ff == STRIP_RESET)
      else $error("strip state not cleared after the end of a list");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      strip_ff.fill != 2'd3)
      else $error("strip window fill out of range");

   a_swap_needs_fill: assert property (@(posedge clock) disable iff (reset)
      strip_ff.swapped |-> strip_ff.fill == FULL_WINDOW)
      else $error("winding swapped before a triangle was emitted");

endmodule : tsa_back
`default_nettype wire
